// ===== design/rgb_sobel_edge_magnitude_core_macros.svh =====
// assertion helpers for the rtl of rsem_back, sampled on clk and held off during rst
`ifndef RGB_SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define RGB_SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// same-cycle implication
`define RSEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rsem_pkg.sv =====
package rsem_pkg;

  // gray weights in q16, they add up to exactly 1.0
  localparam logic [23:0] W_FIRST  = 24'd19595;
  localparam logic [23:0] W_SECOND = 24'd38470;
  localparam logic [23:0] W_THIRD  = 24'd7471;

  localparam int          ROW_W      = 12;
  localparam int          OUT_COL_W  = 11;
  localparam int          GRAD_W     = 11;
  localparam logic [12:0] MAX_ROWS   = 13'd4096;
  localparam logic [7:0]  EDGE_SAT   = 8'd255;
  localparam int          QUEUE_DEPTH = 4;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // register index as decoded from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic is_flush;
    logic row_zero;
    logic first_col;
    logic last_col;
    logic emit_a;
    logic emit_b;
    logic frame_last;
  } rsem_ctrl_t;

  localparam int CTRL_W = $bits(rsem_ctrl_t);

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } rsem_col_t;

  // one line store word: newer row above older row
  typedef struct packed {
    logic [7:0] newer;
    logic [7:0] older;
  } rsem_word_t;

  function automatic logic [GRAD_W-1:0] grad_x(rsem_col_t l, rsem_col_t r);
    logic [GRAD_W-1:0] sl;
    logic [GRAD_W-1:0] sr;
    sl = {3'd0, l.top} + {2'd0, l.mid, 1'b0} + {3'd0, l.bot};
    sr = {3'd0, r.top} + {2'd0, r.mid, 1'b0} + {3'd0, r.bot};
    return sr - sl;
  endfunction

  function automatic logic [GRAD_W-1:0] grad_y(rsem_col_t l, rsem_col_t c, rsem_col_t r);
    logic [GRAD_W-1:0] st;
    logic [GRAD_W-1:0] sb;
    st = {3'd0, l.top} + {2'd0, c.top, 1'b0} + {3'd0, r.top};
    sb = {3'd0, l.bot} + {2'd0, c.bot, 1'b0} + {3'd0, r.bot};
    return sb - st;
  endfunction

  // saturated half of |gx| + |gy|, gradients in two's complement
  function automatic logic [7:0] edge_mag(logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy);
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    logic [GRAD_W:0]   s;
    ax = gx[GRAD_W-1] ? (~gx + 1'b1) : gx;
    ay = gy[GRAD_W-1] ? (~gy + 1'b1) : gy;
    s  = {1'b0, ax} + {1'b0, ay};
    return (s[GRAD_W:1] > {3'd0, EDGE_SAT}) ? EDGE_SAT : s[8:1];
  endfunction

endpackage

// ===== design/rsem_front.sv =====
module rsem_front #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [11:0]                image_width,
  input  logic [12:0]                image_height,
  input  logic                       in_valid,
  input  logic                       room,
  input  logic                       in_kind,
  input  logic [7:0]                 in_first,
  input  logic [7:0]                 in_second,
  input  logic [7:0]                 in_third,
  output logic                       push,
  output rsem_pkg::rsem_ctrl_t       cmd_ctrl,
  output logic [7:0]                 cmd_gray,
  output logic [AW-1:0]              cmd_addr0,
  output logic [AW-1:0]              cmd_addr1,
  output logic [AW-1:0]              cmd_addr2,
  output logic [AW-1:0]              cmd_col,
  output logic [rsem_pkg::ROW_W-1:0] cmd_row
);

  logic [AW-1:0]              pixel_col;
  logic [AW-1:0]              pixel_col_next;
  logic [rsem_pkg::ROW_W-1:0] pixel_row;
  logic [rsem_pkg::ROW_W-1:0] pixel_row_next;
  logic [AW-1:0]              drain_col;
  logic [AW-1:0]              drain_col_next;
  logic                       draining;
  logic                       draining_next;

  logic                       accept;
  logic [AW-1:0]              col_lim;
  logic [rsem_pkg::ROW_W-1:0] row_lim;
  logic [23:0]                gray_sum;
  logic [AW-1:0]              x0, x1, x2;
  logic                       drain_end;
  logic                       row_end;
  logic                       frame_end;

  assign accept = in_valid && room;

  always_comb begin
    if (image_width == '0) begin
      col_lim = '0;
    end else if ({20'd0, image_width} > 32'(MAX_WIDTH)) begin
      col_lim = AW'(MAX_WIDTH - 1);
    end else begin
      col_lim = AW'(image_width - 12'd1);
    end
    if (image_height == '0) begin
      row_lim = '0;
    end else if (image_height > rsem_pkg::MAX_ROWS) begin
      row_lim = '1;
    end else begin
      row_lim = rsem_pkg::ROW_W'(image_height - 13'd1);
    end
  end

  assign gray_sum = rsem_pkg::W_FIRST * {16'd0, in_first}
                  + rsem_pkg::W_SECOND * {16'd0, in_second}
                  + rsem_pkg::W_THIRD * {16'd0, in_third};

  // drain window columns, clamped to the current row end
  always_comb begin
    x1 = (drain_col > col_lim) ? col_lim : drain_col;
    x0 = (x1 != '0) ? x1 - AW'(1) : '0;
    x2 = (x1 < col_lim) ? x1 + AW'(1) : col_lim;
  end

  assign drain_end = drain_col >= col_lim;
  assign row_end   = pixel_col >= col_lim;
  assign frame_end = pixel_row >= row_lim;

  always_comb begin
    cmd_ctrl = '0;
    cmd_gray = gray_sum[23:16];
    if (in_kind == rsem_pkg::KIND_FLUSH) begin
      push                = accept && draining;
      cmd_ctrl.is_flush   = 1'b1;
      cmd_ctrl.emit_b     = 1'b1;
      cmd_ctrl.frame_last = drain_end;
      cmd_addr0           = x0;
      cmd_addr1           = x1;
      cmd_addr2           = x2;
      cmd_col             = drain_col;
      cmd_row             = pixel_row;
    end else begin
      push               = accept && !draining;
      cmd_ctrl.row_zero  = pixel_row == '0;
      cmd_ctrl.first_col = pixel_col == '0;
      cmd_ctrl.last_col  = row_end;
      cmd_ctrl.emit_a    = (pixel_col != '0) && (pixel_row != '0);
      cmd_ctrl.emit_b    = row_end && (pixel_row != '0);
      cmd_addr0          = pixel_col;
      cmd_addr1          = pixel_col;
      cmd_addr2          = pixel_col;
      cmd_col            = pixel_col;
      cmd_row            = pixel_row - 1'b1;
    end
  end

  always_comb begin
    pixel_col_next = pixel_col;
    pixel_row_next = pixel_row;
    drain_col_next = drain_col;
    draining_next  = draining;
    if (push) begin
      if (in_kind == rsem_pkg::KIND_FLUSH) begin
        if (drain_end) begin
          draining_next  = 1'b0;
          drain_col_next = '0;
          pixel_row_next = '0;
          pixel_col_next = '0;
        end else begin
          drain_col_next = drain_col + AW'(1);
        end
      end else if (row_end) begin
        pixel_col_next = '0;
        if (frame_end) begin
          draining_next  = 1'b1;
          drain_col_next = '0;
        end else begin
          pixel_row_next = pixel_row + 1'b1;
        end
      end else begin
        pixel_col_next = pixel_col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_col <= '0;
      pixel_row <= '0;
      drain_col <= '0;
      draining  <= 1'b0;
    end else begin
      pixel_col <= pixel_col_next;
      pixel_row <= pixel_row_next;
      drain_col <= drain_col_next;
      draining  <= draining_next;
    end
  end

endmodule

// ===== design/rsem_queue.sv =====
module rsem_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             room,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = rsem_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign room       = count != (PW+1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/rsem_back.sv =====
`include "rgb_sobel_edge_magnitude_core_macros.svh"

module rsem_back #(
  parameter int MAX_WIDTH = 2048,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  rsem_pkg::rsem_ctrl_t           q_ctrl,
  input  logic [7:0]                     q_gray,
  input  logic [AW-1:0]                  q_addr0,
  input  logic [AW-1:0]                  q_addr1,
  input  logic [AW-1:0]                  q_addr2,
  input  logic [AW-1:0]                  q_col,
  input  logic [rsem_pkg::ROW_W-1:0]     q_row,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_edge,
  output logic [rsem_pkg::OUT_COL_W-1:0] out_col,
  output logic [rsem_pkg::ROW_W-1:0]     out_row,
  output logic                           out_last
);

  localparam int GW = rsem_pkg::GRAD_W;

  // two copies of the line store give three read ports for the drain window
  rsem_pkg::rsem_word_t store_a [MAX_WIDTH];
  rsem_pkg::rsem_word_t store_b [MAX_WIDTH];
  rsem_pkg::rsem_word_t rd0, rd1, rd2;

  logic                       adv;
  logic                       s1_v;
  rsem_pkg::rsem_ctrl_t       s1_ctrl;
  logic [7:0]                 s1_gray;
  logic [AW-1:0]              s1_addr;
  logic [AW-1:0]              s1_col;
  logic [rsem_pkg::ROW_W-1:0] s1_row;
  logic                       s1_byp0, s1_byp1, s1_byp2;
  rsem_pkg::rsem_word_t       s1_fwd;

  rsem_pkg::rsem_col_t [2:0]  win;
  rsem_pkg::rsem_col_t [2:0]  win_a;
  rsem_pkg::rsem_col_t [2:0]  win_b;
  rsem_pkg::rsem_col_t [2:0]  win_next;
  rsem_pkg::rsem_col_t        new_col;
  rsem_pkg::rsem_word_t       w0, w1, w2;
  rsem_pkg::rsem_word_t       wr_word;
  logic                       wr_en;

  logic                       sa, sb;
  logic [GW-1:0]              a_gx, a_gy, b_gx, b_gy;
  logic [AW-1:0]              a_col, b_col;
  logic [rsem_pkg::ROW_W-1:0] a_row, b_row;
  logic                       b_last;
  logic                       out_load;
  logic                       s2_free;

  assign out_load = (!out_valid || out_ready) && (sa || sb);
  assign s2_free  = !(sa || sb) || (out_load && !(sa && sb));
  assign adv      = s2_free;
  assign q_pop    = adv && q_valid;
  assign wr_en    = adv && s1_v && !s1_ctrl.is_flush;

  // entry: line store read, with forwarding from the write in the same beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a[s1_addr] <= wr_word;
      store_b[s1_addr] <= wr_word;
    end
    if (q_pop) begin
      rd0 <= store_a[q_addr0];
      rd1 <= store_a[q_addr1];
      rd2 <= store_b[q_addr2];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctrl <= q_ctrl;
      s1_gray <= q_gray;
      s1_addr <= q_addr0;
      s1_col  <= q_col;
      s1_row  <= q_row;
      s1_byp0 <= wr_en && (s1_addr == q_addr0);
      s1_byp1 <= wr_en && (s1_addr == q_addr1);
      s1_byp2 <= wr_en && (s1_addr == q_addr2);
      s1_fwd  <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= q_valid;
    end
  end

  // window update and gradients
  always_comb begin
    w0 = s1_byp0 ? s1_fwd : rd0;
    w1 = s1_byp1 ? s1_fwd : rd1;
    w2 = s1_byp2 ? s1_fwd : rd2;
    if (s1_ctrl.row_zero) begin
      new_col = '{top: s1_gray, mid: s1_gray, bot: s1_gray};
    end else begin
      new_col = '{top: w0.older, mid: w0.newer, bot: s1_gray};
    end
    wr_word = '{newer: s1_gray, older: new_col.mid};
    if (s1_ctrl.is_flush) begin
      // bottom row replicated below the last row
      win_b[0] = '{top: w0.older, mid: w0.newer, bot: w0.newer};
      win_b[1] = '{top: w1.older, mid: w1.newer, bot: w1.newer};
      win_b[2] = '{top: w2.older, mid: w2.newer, bot: w2.newer};
      win_a    = win_b;
    end else begin
      if (s1_ctrl.first_col) begin
        win_a = {new_col, new_col, new_col};
      end else begin
        win_a = {new_col, win[2], win[1]};
      end
      win_b = {new_col, win_a[2], win_a[1]};
    end
    win_next = (s1_ctrl.is_flush || s1_ctrl.last_col) ? win_b : win_a;
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_gx   <= rsem_pkg::grad_x(win_a[0], win_a[2]);
      a_gy   <= rsem_pkg::grad_y(win_a[0], win_a[1], win_a[2]);
      b_gx   <= rsem_pkg::grad_x(win_b[0], win_b[2]);
      b_gy   <= rsem_pkg::grad_y(win_b[0], win_b[1], win_b[2]);
      a_col  <= s1_col - AW'(1);
      b_col  <= s1_col;
      a_row  <= s1_row;
      b_row  <= s1_row;
      b_last <= s1_ctrl.frame_last;
    end
  end

  // result slots, a goes out before b
  always_ff @(posedge clk) begin
    if (rst) begin
      sa <= 1'b0;
      sb <= 1'b0;
    end else if (adv) begin
      sa <= s1_v && s1_ctrl.emit_a;
      sb <= s1_v && s1_ctrl.emit_b;
    end else if (out_load) begin
      if (sa) begin
        sa <= 1'b0;
      end else begin
        sb <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sa) begin
        out_edge <= rsem_pkg::edge_mag(a_gx, a_gy);
        out_col  <= rsem_pkg::OUT_COL_W'(a_col);
        out_row  <= a_row;
        out_last <= 1'b0;
      end else begin
        out_edge <= rsem_pkg::edge_mag(b_gx, b_gy);
        out_col  <= rsem_pkg::OUT_COL_W'(b_col);
        out_row  <= b_row;
        out_last <= b_last;
      end
    end
  end

  `RSEM_ASSERT_NOW(a_flush_single, s1_v && s1_ctrl.is_flush, !s1_ctrl.emit_a, "flush with two results")
  `RSEM_ASSERT_NOW(a_hold_on_stall, out_valid && !out_ready && (sa || sb), !adv, "slots overwritten")
  `RSEM_ASSERT_NEXT(a_pair_order, out_load && sa && sb, !sa && sb, "result pair out of order")

endmodule

// ===== design/rgb_sobel_edge_magnitude_core.sv =====
// channel  | dir | handshake                      | beat contents
// s_       | in  | s_tvalid / s_tready            | tuser kind, tdata rgb bytes
// m_       | out | m_tvalid / m_tready            | tdata edge/col/row, tlast frame end
// apb      | in  | psel, penable, pwrite, pready  | image_width @0x0, image_height @0x4
//
// one input beat per clock while the command queue has room; a pixel that ends a row
// can give two results; the back end holds until both pass the single output register
// path of a result: command queue, line store read, gradients, output register
// the line store is one write port shared by two read copies; it needs no clearing pass
// rst is synchronous; the input side stalls only when the four-entry command queue fills
module rgb_sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // chan_first, chan_second, chan_third
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // edge_value, out_col, out_row, zero pad
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = rsem_pkg::CTRL_W + 8 + 4 * AW + rsem_pkg::ROW_W;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic        cfg_write;

  logic                       push;
  rsem_pkg::rsem_ctrl_t       f_ctrl;
  logic [7:0]                 f_gray;
  logic [AW-1:0]              f_addr0, f_addr1, f_addr2, f_col;
  logic [rsem_pkg::ROW_W-1:0] f_row;
  logic [QW-1:0]              push_data;

  logic                       room;
  logic                       head_valid;
  logic [QW-1:0]              head_data;
  logic                       pop;
  rsem_pkg::rsem_ctrl_t       h_ctrl;
  logic [7:0]                 h_gray;
  logic [AW-1:0]              h_addr0, h_addr1, h_addr2, h_col;
  logic [rsem_pkg::ROW_W-1:0] h_row;

  logic [7:0]                     r_edge;
  logic [rsem_pkg::OUT_COL_W-1:0] r_col;
  logic [rsem_pkg::ROW_W-1:0]     r_row;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rsem_pkg::WIDTH_RESET;
      image_height <= rsem_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        rsem_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[11:0];
        rsem_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rsem_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, image_width};
      rsem_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, image_height};
      default:                    prdata = '0;
    endcase
  end

  assign s_tready = room;

  rsem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (s_tvalid),
    .room         (room),
    .in_kind      (s_tuser),
    .in_first     (s_tdata[7:0]),
    .in_second    (s_tdata[15:8]),
    .in_third     (s_tdata[23:16]),
    .push         (push),
    .cmd_ctrl     (f_ctrl),
    .cmd_gray     (f_gray),
    .cmd_addr0    (f_addr0),
    .cmd_addr1    (f_addr1),
    .cmd_addr2    (f_addr2),
    .cmd_col      (f_col),
    .cmd_row      (f_row)
  );

  assign push_data = {f_ctrl, f_gray, f_addr0, f_addr1, f_addr2, f_col, f_row};

  rsem_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {h_ctrl, h_gray, h_addr0, h_addr1, h_addr2, h_col, h_row} = head_data;

  rsem_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_ctrl    (h_ctrl),
    .q_gray    (h_gray),
    .q_addr0   (h_addr0),
    .q_addr1   (h_addr1),
    .q_addr2   (h_addr2),
    .q_col     (h_col),
    .q_row     (h_row),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_edge  (r_edge),
    .out_col   (r_col),
    .out_row   (r_row),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, r_row, r_col, r_edge};

endmodule

// ===== dv/rgb_sobel_edge_magnitude_core_test.sv =====
module rgb_sobel_edge_magnitude_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 2048;
  localparam int MAXH = 4096;

  typedef struct packed {
    logic       kind;
    logic [7:0] c3;
    logic [7:0] c2;
    logic [7:0] c1;
  } rgb_beat_t;

  typedef struct packed {
    logic [7:0]  mag;
    logic [10:0] col;
    logic [11:0] row;
    logic        last;
  } edge_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // chan_first, chan_second, chan_third
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // edge_value, out_col, out_row, zero pad
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_sobel_edge_magnitude_core #(.MAX_WIDTH(MAXW)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // gray-level edge predictor state
  logic [11:0]  cfg_width = rsem_pkg::WIDTH_RESET;
  logic [12:0]  cfg_height = rsem_pkg::HEIGHT_RESET;
  logic [7:0]   line_old [0:MAXW-1];
  logic [7:0]   line_new [0:MAXW-1];
  logic [7:0]   win [0:2][0:2] = '{default: '0};
  int unsigned  col_ctr = 0;
  int unsigned  row_ctr = 0;
  int unsigned  drain_ctr = 0;
  bit           draining = 0;

  edge_result_t expected_edges [$];
  rgb_beat_t    beat_q [$];
  rgb_beat_t    next_beat;
  int unsigned  src_hold = 0;
  int unsigned  sink_hold = 0;
  int unsigned  counted = 0;
  int unsigned  mismatches = 0;
  bit           calm = 0;

  function automatic int unsigned eff_w();
    return (cfg_width == 0) ? 1 : ((cfg_width > MAXW) ? MAXW : cfg_width);
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_height == 0) ? 1 : ((cfg_height > MAXH) ? MAXH : cfg_height);
  endfunction

  function automatic void shift_col(logic [7:0] t, logic [7:0] m, logic [7:0] b);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = t;
    win[1][2] = m;
    win[2][2] = b;
  endfunction

  function automatic logic [7:0] window_magnitude();
    int gx;
    int gy;
    int s;
    gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
    gy = (win[2][0] + 2 * win[2][1] + win[2][2]) - (win[0][0] + 2 * win[0][1] + win[0][2]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    s = (gx + gy) >> 1;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic void expect_edge(int unsigned col, int unsigned row, bit last);
    edge_result_t e;
    e.mag  = window_magnitude();
    e.col  = col[10:0];
    e.row  = row[11:0];
    e.last = last;
    expected_edges.push_back(e);
  endfunction

  function automatic void sobel_step(logic kind, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int unsigned w;
    int unsigned h;
    int unsigned d;
    int unsigned lim;
    int unsigned x0;
    int unsigned x1;
    int unsigned x2;
    int unsigned g;
    int unsigned ci;
    logic [7:0]  t;
    logic [7:0]  m;
    bit          last;
    w = eff_w();
    h = eff_h();
    if (kind == rsem_pkg::KIND_FLUSH) begin
      if (!draining) return;
      d   = drain_ctr;
      lim = w - 1;
      x1  = (d > lim) ? lim : d;
      x0  = (x1 > 0) ? x1 - 1 : 0;
      x2  = (x1 < lim) ? x1 + 1 : lim;
      // rows below the last one are replicated
      shift_col(line_old[x0], line_new[x0], line_new[x0]);
      shift_col(line_old[x1], line_new[x1], line_new[x1]);
      shift_col(line_old[x2], line_new[x2], line_new[x2]);
      last = (d >= w - 1);
      expect_edge(d, row_ctr, last);
      if (last) begin
        draining  = 0;
        drain_ctr = 0;
        row_ctr   = 0;
        col_ctr   = 0;
      end else begin
        drain_ctr = (d + 1) & 32'hFFF;
      end
    end else begin
      if (draining) return;
      g  = (rsem_pkg::W_FIRST * a + rsem_pkg::W_SECOND * b + rsem_pkg::W_THIRD * c) >> 16;
      ci = (col_ctr < MAXW) ? col_ctr : MAXW - 1;
      if (row_ctr == 0) begin
        t = g[7:0];
        m = g[7:0];
      end else begin
        t = line_old[ci];
        m = line_new[ci];
      end
      line_old[ci] = m;
      line_new[ci] = g[7:0];
      if (col_ctr == 0) begin
        // left border replicated
        shift_col(t, m, g[7:0]);
        shift_col(t, m, g[7:0]);
        shift_col(t, m, g[7:0]);
      end else begin
        shift_col(t, m, g[7:0]);
        if (row_ctr >= 1) expect_edge(col_ctr - 1, row_ctr - 1, 0);
      end
      if (col_ctr >= w - 1) begin
        shift_col(t, m, g[7:0]);
        if (row_ctr >= 1) expect_edge(col_ctr, row_ctr - 1, 0);
        col_ctr = 0;
        if (row_ctr >= h - 1) begin
          draining  = 1;
          drain_ctr = 0;
        end else begin
          row_ctr = row_ctr + 1;
        end
      end else begin
        col_ctr = col_ctr + 1;
      end
    end
  endfunction

  function automatic void report_bad(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // stream source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        sobel_step(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
      if (!s_tvalid || s_tready) begin
        if (src_hold != 0) begin
          src_hold--;
          s_tvalid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          next_beat = beat_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_beat.kind;
          s_tdata  <= {next_beat.c3, next_beat.c2, next_beat.c1};
          if (!calm && $urandom_range(0, 11) == 0) src_hold = $urandom_range(1, 8);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    edge_result_t got;
    edge_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.mag  = m_tdata[7:0];
      got.col  = m_tdata[18:8];
      got.row  = m_tdata[30:19];
      got.last = m_tlast;
      if (expected_edges.size() == 0) begin
        report_bad($sformatf("unexpected beat: edge %0d col %0d row %0d last %0b",
                             got.mag, got.col, got.row, got.last));
      end else begin
        want = expected_edges.pop_front();
        if (got != want)
          report_bad($sformatf({"edge mismatch: want edge %0d col %0d row %0d last %0b,",
                                " got edge %0d col %0d row %0d last %0b"},
                               want.mag, want.col, want.row, want.last,
                               got.mag, got.col, got.row, got.last));
      end
    end
    if (sink_hold != 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 15) == 0) sink_hold = $urandom_range(1, 8);
    end
  end

  task automatic program_reg(logic idx, int unsigned value);
    logic [31:0] word;
    logic [31:0] want;
    logic [31:0] got;
    word = $urandom;
    if (idx == rsem_pkg::REG_IMAGE_WIDTH) begin
      word[11:0] = value[11:0];
      want = {20'd0, value[11:0]};
    end else begin
      word[12:0] = value[12:0];
      want = {19'd0, value[12:0]};
    end
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == rsem_pkg::REG_IMAGE_WIDTH) cfg_width = want[11:0];
    else cfg_height = want[12:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_bad($sformatf("register %0d readback: want %0h got %0h", idx, want, got));
  endtask

  task automatic wait_idle();
    while (beat_q.size() != 0 || s_tvalid || expected_edges.size() != 0) @(posedge clk);
    // pixels that give no result may still be in the pipe
    repeat (12) @(posedge clk);
  endtask

  function automatic void queue_beat(logic kind, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    rgb_beat_t nb;
    nb.kind = kind;
    nb.c1   = a;
    nb.c2   = b;
    nb.c3   = c;
    beat_q.push_back(nb);
  endfunction

  function automatic logic [7:0] pick_chan(bit harsh);
    if (harsh) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_run(logic kind, int unsigned n, bit noisy);
    bit harsh;
    for (int unsigned i = 0; i < n; i++) begin
      // an out-of-phase beat is dropped by the block
      if (noisy && $urandom_range(0, 15) == 0)
        queue_beat(~kind, pick_chan(0), pick_chan(0), pick_chan(0));
      harsh = ($urandom_range(0, 3) == 0);
      queue_beat(kind, pick_chan(harsh), pick_chan(harsh), pick_chan(harsh));
      counted++;
    end
  endfunction

  // only valid while idle, when the predictor has seen every beat
  function automatic void push_frame_rest(bit noisy);
    int unsigned w;
    int unsigned h;
    int unsigned pix;
    int unsigned fl;
    w   = eff_w();
    h   = eff_h();
    pix = 0;
    if (draining) begin
      fl = (drain_ctr >= w - 1) ? 1 : w - drain_ctr;
    end else begin
      pix = (col_ctr >= w - 1) ? 1 : w - col_ctr;
      if (row_ctr < h - 1) pix += (h - 1 - row_ctr) * w;
      fl = w;
    end
    push_run(rsem_pkg::KIND_PIXEL, pix, noisy);
    push_run(rsem_pkg::KIND_FLUSH, fl, noisy);
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(11, 48);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  initial begin
    int unsigned k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small frame with hard contrasts, stray beats in both phases
    program_reg(rsem_pkg::REG_IMAGE_WIDTH, 4);
    program_reg(rsem_pkg::REG_IMAGE_HEIGHT, 3);
    queue_beat(rsem_pkg::KIND_FLUSH, 8'h12, 8'h34, 8'h56);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'h00, 8'h00);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'h00, 8'hFF, 8'h00);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'hFF);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hAA, 8'h55, 8'hAA);
    repeat (4) queue_beat(rsem_pkg::KIND_FLUSH, 8'h00, 8'h00, 8'h00);

    // zero sizes clamp to a single pixel
    wait_idle();
    program_reg(rsem_pkg::REG_IMAGE_WIDTH, 0);
    program_reg(rsem_pkg::REG_IMAGE_HEIGHT, 0);
    queue_beat(rsem_pkg::KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(rsem_pkg::KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);

    // one wide row writes every line store column the random frames can reach
    wait_idle();
    program_reg(rsem_pkg::REG_IMAGE_WIDTH, 48);
    program_reg(rsem_pkg::REG_IMAGE_HEIGHT, 1);
    push_frame_rest(0);

    counted = 0;
    while (counted < 1800) begin
      if (counted > 1500) calm = 1;
      wait_idle();
      program_reg(rsem_pkg::REG_IMAGE_WIDTH, pick_width());
      program_reg(rsem_pkg::REG_IMAGE_HEIGHT, pick_height());
      if ($urandom_range(0, 4) == 0 && eff_w() * eff_h() >= 2) begin
        // resize part way through a frame
        k = $urandom_range(1, eff_w() * eff_h() - 1);
        push_run(rsem_pkg::KIND_PIXEL, k, 0);
        wait_idle();
        if ($urandom_range(0, 1)) program_reg(rsem_pkg::REG_IMAGE_WIDTH, pick_width());
        if ($urandom_range(0, 1)) program_reg(rsem_pkg::REG_IMAGE_HEIGHT, pick_height());
      end
      push_frame_rest($urandom_range(0, 3) == 0);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rsem_pkg.sv
design/rsem_front.sv
design/rsem_queue.sv
design/rsem_back.sv
design/rgb_sobel_edge_magnitude_core.sv
dv/rgb_sobel_edge_magnitude_core_test.sv
